>>> rtl/core/sfr_pkg.sv
// shared types and constants for the stream find and replace block
`timescale 1ns / 1ps

package sfr_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_PATTERN_BYTES      = 2'd0;
	localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
	localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
	localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

	// command broadcast to every window cell
	typedef struct packed {
		logic       append;  // new byte enters the cell picked by its select
		logic       shift;   // every cell takes its upper neighbor's byte, the last cell takes zero
		logic [7:0] data;    // the new byte
	} cell_cmd_t;

endpackage

>>> rtl/core/sfr_cell.sv
// one window cell: holds a byte, compares it and its neighbor's byte against its pattern byte
`timescale 1ns / 1ps

module sfr_cell import sfr_pkg::*; (
	input  logic       clk,
	input  cell_cmd_t  cmd,
	input  logic       sel,
	input  logic [7:0] next_cur,
	input  logic [7:0] pat,
	output logic [7:0] cur,
	output logic       eq_here,
	output logic       eq_shift
);

	logic [7:0] byte_q;

	// content as seen this cycle, including a byte that is being appended
	assign cur      = (cmd.append && sel) ? cmd.data : byte_q;
	assign eq_here  = (cur == pat);
	assign eq_shift = (next_cur == pat);

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			byte_q <= next_cur;
		end else if (cmd.append && sel) begin
			byte_q <= cmd.data;
		end
	end

endmodule

>>> rtl/core/stream_find_replace.sv
// top level of the streaming find and replace block
`timescale 1ns / 1ps

// stream_find_replace
// replaces every leftmost, non-overlapping occurrence of a configured pattern
// in a byte stream with a configured replacement
// input channel: in_valid / in_stall with in_byte and in_last; a transaction
//   with in_last set ends the document, flushes held bytes and tags the final
//   output transaction with out_last and any_replaced
// output channel: out_valid / out_stall with out_byte, has_byte, out_last and
//   any_replaced; a bare end marker (has_byte low) appears when the last
//   input produces no byte
// config channel: cfg_valid / cfg_ready (always ready) with cfg_index and
//   cfg_data; write only while no output is outstanding
// the first output transaction for an accepted input is registered and appears in the cycle after acceptance
// an input that yields several outputs raises in_stall while the sequencer sends
//   them, since the output register takes one byte per cycle while out_stall is
//   low (drain of held bytes or replacement bytes)
// the window is a row of cells that shifts toward cell zero on each drop
// reset clears the configuration and control registers, the window count and the output valid flag
// when the receiver stalls the output holds and in_stall is raised

module stream_find_replace import sfr_pkg::*; #(
	parameter int PATTERN_MAX = 8,
	parameter int REPLACE_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        out_last,
	output logic        any_replaced,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int CW = $clog2(PATTERN_MAX + 1);               // window count width
	localparam int RW = $clog2(REPLACE_MAX + 1);               // replacement length width
	localparam int RI = (REPLACE_MAX > 1) ? $clog2(REPLACE_MAX) : 1;  // replacement index
	localparam int RD = 2 ** RI;

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_REPL  = 2'd2;

	// configuration registers
	logic [63:0] pat_q;
	logic [3:0]  plen_q;
	logic [63:0] rep_q;
	logic [3:0]  rlen_q;

	// control state
	logic [1:0]    state_q, state_n;
	logic [CW-1:0] count_q, count_n;
	logic [RI-1:0] ridx_q, ridx_n;
	logic          last_q, last_n;
	logic          seen_q, seen_n;

	// output register
	logic       ov_q;
	logic [7:0] ob_q;
	logic       oh_q, ol_q, oa_q;

	// datapath
	cell_cmd_t     cmd;
	logic          adv, accept;
	logic [CW-1:0] plen;
	logic [RW-1:0] rlen;
	logic [7:0]    rep_arr [RD];
	logic [7:0]    cur_arr [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] eq_here, eq_shift, sel;

	logic [CW-1:0] ccur, cm1;
	logic          last_now, ok_here, ok_shift, pfx_here, pfx_shift, match, more;
	logic          emit, e_has, e_final, e_any;
	logic [7:0]    e_byte;

	// saturate the lengths to what the hardware holds
	assign plen = (plen_q > 4'(PATTERN_MAX)) ? CW'(PATTERN_MAX) : CW'(plen_q);
	assign rlen = (rlen_q > 4'(REPLACE_MAX)) ? RW'(REPLACE_MAX) : RW'(rlen_q);

	// output side advances when the register is empty or being taken
	assign adv      = !ov_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !adv;
	assign accept   = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= '0;
			rep_q  <= '0;
			rlen_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PATTERN_BYTES:      pat_q  <= cfg_data;
				CFG_PATTERN_LENGTH:     plen_q <= cfg_data[3:0];
				CFG_REPLACEMENT_BYTES:  rep_q  <= cfg_data;
				CFG_REPLACEMENT_LENGTH: rlen_q <= cfg_data[3:0];
			endcase
		end
	end

	// replacement bytes as a small lookup by index
	generate
		for (genvar r = 0; r < RD; r++) begin : g_rep
			assign rep_arr[r] = rep_q[8*r +: 8];
		end
	endgenerate

	// row of window cells, cell zero holds the oldest byte
	generate
		for (genvar c = 0; c < PATTERN_MAX; c++) begin : g_cell
			logic [7:0] nxt;
			if (c == PATTERN_MAX - 1) begin : g_end
				assign nxt = 8'h00;
			end else begin : g_mid
				assign nxt = cur_arr[c+1];
			end
			assign sel[c] = (count_q == CW'(c));
			sfr_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.sel      (sel[c]),
				.next_cur (nxt),
				.pat      (pat_q[8*c +: 8]),
				.cur      (cur_arr[c]),
				.eq_here  (eq_here[c]),
				.eq_shift (eq_shift[c])
			);
		end
	endgenerate

	always_comb begin
		cmd.append = accept;
		cmd.shift  = 1'b0;
		cmd.data   = in_byte;
		state_n    = state_q;
		count_n    = count_q;
		ridx_n     = ridx_q;
		last_n     = last_q;
		seen_n     = seen_q;
		emit       = 1'b0;
		e_has      = 1'b0;
		e_byte     = 8'h00;
		e_final    = 1'b0;
		e_any      = 1'b0;

		// window count as seen this cycle, and after one drop
		ccur     = accept ? count_q + CW'(1) : count_q;
		cm1      = ccur - CW'(1);
		last_now = accept ? in_last : last_q;

		// per-cell prefix checks, for the window as is and shifted by one
		ok_here  = 1'b1;
		ok_shift = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (CW'(i) < ccur && !eq_here[i]) begin
				ok_here = 1'b0;
			end
			if (CW'(i) < cm1 && !eq_shift[i]) begin
				ok_shift = 1'b0;
			end
		end
		pfx_here  = ok_here && (ccur <= plen);
		pfx_shift = ok_shift && (cm1 <= plen);
		match     = (plen != '0) && (ccur == plen) && pfx_here;
		// another drop still needed after this one
		more      = (cm1 != '0) && (last_now || plen == '0 || !pfx_shift);

		if (accept) begin
			last_n = in_last;
			if (match) begin
				// full pattern: send the replacement, empty the window
				seen_n  = 1'b1;
				count_n = '0;
				ridx_n  = RI'(1);
				if (rlen != '0) begin
					emit    = 1'b1;
					e_has   = 1'b1;
					e_byte  = rep_arr[0];
					e_final = in_last && (rlen == RW'(1));
					if (rlen > RW'(1)) begin
						state_n = ST_REPL;
					end
				end else if (in_last) begin
					emit    = 1'b1;
					e_final = 1'b1;
				end
			end else if (plen == '0 || !pfx_here || in_last) begin
				// oldest byte can no longer start a match, or flush
				emit      = 1'b1;
				e_has     = 1'b1;
				e_byte    = cur_arr[0];
				cmd.shift = 1'b1;
				count_n   = cm1;
				e_final   = in_last && (cm1 == '0);
				if (more) begin
					state_n = ST_DRAIN;
				end
			end else begin
				count_n = ccur;
			end
		end else if (adv) begin
			unique case (state_q)
				ST_DRAIN: begin
					emit      = 1'b1;
					e_has     = 1'b1;
					e_byte    = cur_arr[0];
					cmd.shift = 1'b1;
					count_n   = cm1;
					e_final   = last_q && (cm1 == '0);
					if (!more) begin
						state_n = ST_IDLE;
					end
				end
				ST_REPL: begin
					emit    = 1'b1;
					e_has   = 1'b1;
					e_byte  = rep_arr[ridx_q];
					ridx_n  = ridx_q + RI'(1);
					if (RW'(ridx_q) == rlen - RW'(1)) begin
						e_final = last_q;
						state_n = ST_IDLE;
					end
				end
				default: begin
				end
			endcase
		end

		// end of document: report and clear the per-document state
		if (e_final) begin
			e_any   = seen_n;
			seen_n  = 1'b0;
			count_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ridx_q  <= '0;
			last_q  <= 1'b0;
			seen_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			ridx_q  <= ridx_n;
			last_q  <= last_n;
			seen_q  <= seen_n;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (adv) begin
				ov_q <= 1'b0;
			end
		end
	end

	// output payload, loaded only when a transaction is produced
	always_ff @(posedge clk) begin
		if (emit) begin
			ob_q <= e_byte;
			oh_q <= e_has;
			ol_q <= e_final;
			oa_q <= e_any;
		end
	end

	assign out_valid    = ov_q;
	assign out_byte     = ob_q;
	assign has_byte     = oh_q;
	assign out_last     = ol_q;
	assign any_replaced = oa_q;

endmodule
